/* rtl/isfn_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isfn_pkg
// Shared types and constants of the sample-to-intensity mapper.
// ----------------------------------------------------------------------------
package isfn_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int NOISE_W     = 17;
    localparam int INTENS_W    = 16;
    localparam int NFIELD_W    = 16;
    localparam int DEST_W      = 24;
    localparam int SUM_W       = 56;
    localparam int FMT_W       = 2;
    localparam int WIDTH_REG_W = 13;
    localparam int COUNT_REG_W = 25;
    localparam int DONE_W      = 24;

    localparam int MAX_WIDTH_DEF  = 4096;
    localparam int MAX_PIXELS_DEF = 16777216;

    localparam int QUEUE_DEPTH = 2;

    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    // Intensity and noise-field limits per format size
    localparam logic [INTENS_W:0] MAX_16 = 17'd65535;
    localparam logic [INTENS_W:0] MAX_8  = 17'd255;
    localparam logic signed [INTENS_W+1:0] NLO_16 = -18'sd32768;
    localparam logic signed [INTENS_W+1:0] NHI_16 = 18'sd32767;
    localparam logic signed [INTENS_W+1:0] NLO_8  = -18'sd128;
    localparam logic signed [INTENS_W+1:0] NHI_8  = 18'sd127;

    typedef enum logic [FMT_W-1:0] {
        FMT_S16 = 2'd0,
        FMT_U16 = 2'd1,
        FMT_U8  = 2'd2,
        FMT_S8  = 2'd3
    } fmt_t;

    typedef enum logic [2:0] {
        CFG_SOURCE_FORMAT = 3'd0,
        CFG_INVERT_MODE   = 3'd1,
        CFG_IMAGE_WIDTH   = 3'd2,
        CFG_PIXEL_COUNT   = 3'd3,
        CFG_NOISE_ENABLE  = 3'd4
    } cfg_index_t;

    // One classified item handed from the front part to the back part
    typedef struct packed {
        logic [INTENS_W-1:0]       base;
        logic                      is8;
        logic signed [NOISE_W-1:0] noise;
        logic                      nf_en;
        logic [DEST_W-1:0]         dest;
        logic                      last;
        logic                      start;
    } item_t;

    // Settings the front part works from
    typedef struct packed {
        logic [FMT_W-1:0]       source_format;
        logic                   invert_mode;
        logic [WIDTH_REG_W-1:0] image_width;
        logic [COUNT_REG_W-1:0] pixel_count;
        logic                   noise_field_enable;
    } cfg_t;

endpackage

/* rtl/int_sample_to_intensity_flip_noise_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// int_sample_to_intensity_flip_noise_top
// Maps raw pixel samples to noised, clamped intensities in flipped row order.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake               payload
//  s_axis    in         tvalid / tready         tdata: sample, noise
//  m_axis    out        tvalid / tready         tdata: intensity, noise_field,
//                                               dest_index, square_sum; tlast
//  apb       in         psel / penable / pready 5 registers at 4*i
//
//  One item per cycle sustained while the sink keeps tready high. Items pass
//  through the queue, then the add, clamp and square stages; the accumulate
//  and the output register load together. The 56-bit running total is
//  registered and feeds back into its adder. Reset clears the frame state,
//  configuration, valid flags and total; no clearing pass is needed.
//  The queue lets the front keep taking items while the back is stalled,
//  until two items wait; the output register decouples the sink.
//
module int_sample_to_intensity_flip_noise_top #(
    parameter int MAX_WIDTH  = isfn_pkg::MAX_WIDTH_DEF,
    parameter int MAX_PIXELS = isfn_pkg::MAX_PIXELS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,

    // Input items
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [39:0]                         s_axis_tdata,  // [15:0] sample, [32:16] noise

    // Result items
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [111:0]                        m_axis_tdata,  // [15:0] intensity,
                                                               // [31:16] noise_field,
                                                               // [55:32] dest_index,
                                                               // [111:56] square_sum
    output logic                                m_axis_tlast,  // frame_last

    // Configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [isfn_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [isfn_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [isfn_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);

    isfn_pkg::cfg_t   cfg_reg, cfg_next;
    isfn_pkg::item_t  push_item;
    isfn_pkg::item_t  pop_item;
    isfn_pkg::cfg_index_t reg_sel;

    logic                               wr_en;
    logic                               q_push;
    logic                               q_full;
    logic                               q_valid;
    logic                               q_pop;
    logic [isfn_pkg::INTENS_W-1:0]      intensity;
    logic [isfn_pkg::NFIELD_W-1:0]      noise_field;
    logic [isfn_pkg::DEST_W-1:0]        dest_index;
    logic [isfn_pkg::SUM_W-1:0]         square_sum;

    // ---------------------------------------------------------------- config
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_sel = isfn_pkg::cfg_index_t'(paddr[4:2]);

    // Decode the write; addresses past the last register are ignored
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_sel)
                isfn_pkg::CFG_SOURCE_FORMAT:
                    cfg_next.source_format = pwdata[isfn_pkg::FMT_W-1:0];
                isfn_pkg::CFG_INVERT_MODE:
                    cfg_next.invert_mode = pwdata[0];
                isfn_pkg::CFG_IMAGE_WIDTH:
                    cfg_next.image_width = pwdata[isfn_pkg::WIDTH_REG_W-1:0];
                isfn_pkg::CFG_PIXEL_COUNT:
                    cfg_next.pixel_count = pwdata[isfn_pkg::COUNT_REG_W-1:0];
                isfn_pkg::CFG_NOISE_ENABLE:
                    cfg_next.noise_field_enable = pwdata[0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    // Read back the addressed register, zero-extended
    always_comb
    begin
        unique case (reg_sel)
            isfn_pkg::CFG_SOURCE_FORMAT:
                prdata = isfn_pkg::APB_DATA_W'(cfg_reg.source_format);
            isfn_pkg::CFG_INVERT_MODE:
                prdata = isfn_pkg::APB_DATA_W'(cfg_reg.invert_mode);
            isfn_pkg::CFG_IMAGE_WIDTH:
                prdata = isfn_pkg::APB_DATA_W'(cfg_reg.image_width);
            isfn_pkg::CFG_PIXEL_COUNT:
                prdata = isfn_pkg::APB_DATA_W'(cfg_reg.pixel_count);
            isfn_pkg::CFG_NOISE_ENABLE:
                prdata = isfn_pkg::APB_DATA_W'(cfg_reg.noise_field_enable);
            default:
                prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.source_format      <= '0;
            cfg_reg.invert_mode        <= 1'b0;
            cfg_reg.image_width        <= isfn_pkg::WIDTH_REG_W'(1);
            cfg_reg.pixel_count        <= isfn_pkg::COUNT_REG_W'(1);
            cfg_reg.noise_field_enable <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // ------------------------------------------------------------ front part
    // Map the sample, track row and frame position
    isfn_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_PIXELS (MAX_PIXELS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sample   (s_axis_tdata[15:0]),
        .noise    ($signed(s_axis_tdata[32:16])),
        .q_push   (q_push),
        .q_full   (q_full),
        .q_item   (push_item)
    );

    // ----------------------------------------------------------------- queue
    isfn_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop_valid (q_valid),
        .pop       (q_pop),
        .pop_item  (pop_item)
    );

    // ------------------------------------------------------------- back part
    // Add noise, clamp, square and accumulate per frame
    isfn_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (q_valid),
        .item_pop    (q_pop),
        .item        (pop_item),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .intensity   (intensity),
        .noise_field (noise_field),
        .dest_index  (dest_index),
        .square_sum  (square_sum),
        .frame_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {square_sum, dest_index, noise_field, intensity};

endmodule

/* rtl/isfn_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isfn_front
// Accepts samples, maps them to a base intensity and tracks frame position.
// ----------------------------------------------------------------------------
module isfn_front #(
    parameter int MAX_WIDTH  = isfn_pkg::MAX_WIDTH_DEF,
    parameter int MAX_PIXELS = isfn_pkg::MAX_PIXELS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  isfn_pkg::cfg_t                        cfg,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [isfn_pkg::SAMPLE_W-1:0]         sample,
    input  logic signed [isfn_pkg::NOISE_W-1:0]   noise,
    output logic                                  q_push,
    input  logic                                  q_full,
    output isfn_pkg::item_t                       q_item
);

    localparam int CW = $clog2(MAX_WIDTH + 1);

    logic [isfn_pkg::DONE_W-1:0]      pixels_done_reg, pixels_done_next;
    logic [isfn_pkg::DEST_W-1:0]      dest_ptr_reg, dest_ptr_next;
    logic [CW-1:0]                    col_reg, col_next;

    logic [isfn_pkg::WIDTH_REG_W-1:0] eff_width;
    logic [isfn_pkg::COUNT_REG_W-1:0] eff_count;
    logic [isfn_pkg::DEST_W-1:0]      frame_base;
    logic [isfn_pkg::DEST_W-1:0]      dest;
    logic [isfn_pkg::DEST_W-1:0]      wrap_step;
    logic [CW-1:0]                    col_cur;
    logic [CW-1:0]                    col_inc;
    logic                             start;
    logic                             last;
    logic                             wrap;
    logic                             accept;
    logic [isfn_pkg::INTENS_W-1:0]    straight;
    logic [isfn_pkg::INTENS_W-1:0]    base;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign q_push   = accept;

    // Clamp width and count to the supported range
    always_comb
    begin
        if (cfg.image_width == '0)
            eff_width = isfn_pkg::WIDTH_REG_W'(1);
        else if (32'(cfg.image_width) > 32'(MAX_WIDTH))
            eff_width = isfn_pkg::WIDTH_REG_W'(MAX_WIDTH);
        else
            eff_width = cfg.image_width;

        if (cfg.pixel_count == '0)
            eff_count = isfn_pkg::COUNT_REG_W'(1);
        else if (32'(cfg.pixel_count) > 32'(MAX_PIXELS))
            eff_count = isfn_pkg::COUNT_REG_W'(MAX_PIXELS);
        else
            eff_count = cfg.pixel_count;
    end

    // Frame position: start of the last row, walking rows upward
    always_comb
    begin
        start      = (pixels_done_reg == '0);
        frame_base = isfn_pkg::DEST_W'(eff_count - isfn_pkg::COUNT_REG_W'(eff_width));
        dest       = start ? frame_base : dest_ptr_reg;
        col_cur    = start ? '0 : col_reg;
        col_inc    = col_cur + CW'(1);
        wrap       = (32'(col_inc) >= 32'(eff_width));
        wrap_step  = isfn_pkg::DEST_W'(1)
                     - isfn_pkg::DEST_W'({eff_width, 1'b0});
        last       = ({1'b0, pixels_done_reg} + 25'd1) >= eff_count;

        dest_ptr_next    = dest + (wrap ? wrap_step : isfn_pkg::DEST_W'(1));
        col_next         = wrap ? '0 : col_inc;
        pixels_done_next = last ? '0 : pixels_done_reg + isfn_pkg::DONE_W'(1);
    end

    // Map the raw sample; inverted mapping is the complement within the format width
    always_comb
    begin
        unique case (isfn_pkg::fmt_t'(cfg.source_format))
            isfn_pkg::FMT_S16: straight = sample ^ 16'h8000;
            isfn_pkg::FMT_U16: straight = sample;
            isfn_pkg::FMT_U8:  straight = {8'h00, sample[7:0]};
            isfn_pkg::FMT_S8:  straight = {8'h00, sample[7:0] ^ 8'h80};
            default:           straight = sample;
        endcase
        if (!cfg.invert_mode)
            base = straight;
        else if (cfg.source_format[1])
            base = {8'h00, ~straight[7:0]};
        else
            base = ~straight;
    end

    always_comb
    begin
        q_item.base  = base;
        q_item.is8   = cfg.source_format[1];
        q_item.noise = noise;
        q_item.nf_en = cfg.noise_field_enable;
        q_item.dest  = dest;
        q_item.last  = last;
        q_item.start = start;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixels_done_reg <= '0;
            dest_ptr_reg    <= '0;
            col_reg         <= '0;
        end
        else if (accept)
        begin
            pixels_done_reg <= pixels_done_next;
            dest_ptr_reg    <= dest_ptr_next;
            col_reg         <= col_next;
        end
    end

endmodule

/* rtl/isfn_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isfn_queue
// Short item queue between the front and back parts.
// ----------------------------------------------------------------------------
module isfn_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  isfn_pkg::item_t push_item,
    output logic            full,
    output logic            pop_valid,
    input  logic            pop,
    output isfn_pkg::item_t pop_item
);

    localparam int PW = $clog2(isfn_pkg::QUEUE_DEPTH);
    localparam int NW = $clog2(isfn_pkg::QUEUE_DEPTH + 1);

    isfn_pkg::item_t mem_reg [isfn_pkg::QUEUE_DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0]   cnt_reg, cnt_next;
    logic            do_push;
    logic            do_pop;

    assign full      = (cnt_reg == NW'(isfn_pkg::QUEUE_DEPTH));
    assign pop_valid = (cnt_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;
    assign pop_item  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
            wr_ptr_next = (32'(wr_ptr_reg) == isfn_pkg::QUEUE_DEPTH - 1) ? '0
                          : wr_ptr_reg + PW'(1);
        if (do_pop)
            rd_ptr_next = (32'(rd_ptr_reg) == isfn_pkg::QUEUE_DEPTH - 1) ? '0
                          : rd_ptr_reg + PW'(1);
        cnt_next = cnt_reg + NW'(do_push) - NW'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

/* rtl/isfn_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isfn_back
// Adds noise, clamps, squares the difference and accumulates per frame.
// ----------------------------------------------------------------------------
module isfn_back (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 item_valid,
    output logic                                 item_pop,
    input  isfn_pkg::item_t                      item,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [isfn_pkg::INTENS_W-1:0]        intensity,
    output logic [isfn_pkg::NFIELD_W-1:0]        noise_field,
    output logic [isfn_pkg::DEST_W-1:0]          dest_index,
    output logic [isfn_pkg::SUM_W-1:0]           square_sum,
    output logic                                 frame_last
);

    localparam int IW = isfn_pkg::INTENS_W;

    // Stage 1: raw sum and the difference that applies on overflow
    logic                     v1_reg;
    logic signed [IW+1:0]     sum1_reg;
    logic signed [IW+1:0]     ovr1_reg;
    logic [IW-1:0]            base1_reg;
    logic signed [IW+1:0]     noise1_reg;
    logic [IW:0]              max1_reg;
    logic                     is8_1_reg;
    logic                     nfen1_reg;
    logic [isfn_pkg::DEST_W-1:0] dest1_reg;
    logic                     last1_reg;
    logic                     start1_reg;

    // Stage 2: clamped intensity, noise field, magnitude
    logic                     v2_reg;
    logic [IW-1:0]            val2_reg;
    logic [IW-1:0]            nf2_reg;
    logic [IW-1:0]            adif2_reg;
    logic [isfn_pkg::DEST_W-1:0] dest2_reg;
    logic                     last2_reg;
    logic                     start2_reg;

    // Stage 3: square
    logic                     v3_reg;
    logic [2*IW-1:0]          sq3_reg;
    logic [IW-1:0]            val3_reg;
    logic [IW-1:0]            nf3_reg;
    logic [isfn_pkg::DEST_W-1:0] dest3_reg;
    logic                     last3_reg;
    logic                     start3_reg;

    // Output register, holding the frame total
    logic                     ov_reg;
    logic [IW-1:0]            val_o_reg;
    logic [IW-1:0]            nf_o_reg;
    logic [isfn_pkg::DEST_W-1:0] dest_o_reg;
    logic                     last_o_reg;
    logic [isfn_pkg::SUM_W-1:0] total_reg, total_next;

    logic en1, en2, en3, en4;
    logic [IW:0]              max_in;
    logic signed [IW+1:0]     sum_in;
    logic signed [IW+1:0]     dif2;
    logic [IW-1:0]            val2;
    logic signed [IW+1:0]     nlo2;
    logic signed [IW+1:0]     nhi2;
    logic signed [IW+1:0]     nfw2;
    logic [IW+1:0]            mag2;

    assign en4      = !ov_reg || out_ready;
    assign en3      = !v3_reg || en4;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign item_pop = item_valid && en1;

    assign max_in = item.is8 ? isfn_pkg::MAX_8 : isfn_pkg::MAX_16;
    assign sum_in = $signed({2'b00, item.base}) + (IW+2)'(item.noise);

    // Clamp: below zero, above the format maximum, or pass the noise through
    always_comb
    begin
        priority if (sum1_reg < 0)
        begin
            val2 = '0;
            dif2 = -$signed({2'b00, base1_reg});
        end
        else if (sum1_reg > $signed({1'b0, max1_reg}))
        begin
            val2 = max1_reg[IW-1:0];
            dif2 = ovr1_reg;
        end
        else
        begin
            val2 = sum1_reg[IW-1:0];
            dif2 = noise1_reg;
        end

        nlo2 = is8_1_reg ? isfn_pkg::NLO_8 : isfn_pkg::NLO_16;
        nhi2 = is8_1_reg ? isfn_pkg::NHI_8 : isfn_pkg::NHI_16;
        priority if (!nfen1_reg)
            nfw2 = '0;
        else if (dif2 < nlo2)
            nfw2 = nlo2;
        else if (dif2 > nhi2)
            nfw2 = nhi2;
        else
            nfw2 = dif2;

        mag2 = (dif2 < 0) ? (IW+2)'(-dif2) : (IW+2)'(dif2);
    end

    assign total_next = (start3_reg ? '0 : total_reg)
                        + isfn_pkg::SUM_W'(sq3_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            ov_reg    <= 1'b0;
            total_reg <= '0;
        end
        else
        begin
            if (en1)
                v1_reg <= item_valid;
            if (en2)
                v2_reg <= v1_reg;
            if (en3)
                v3_reg <= v2_reg;
            if (en4)
                ov_reg <= v3_reg;
            if (en4 && v3_reg)
                total_reg <= total_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            sum1_reg   <= sum_in;
            ovr1_reg   <= $signed({1'b0, max_in}) - $signed({2'b00, item.base});
            base1_reg  <= item.base;
            noise1_reg <= (IW+2)'(item.noise);
            max1_reg   <= max_in;
            is8_1_reg  <= item.is8;
            nfen1_reg  <= item.nf_en;
            dest1_reg  <= item.dest;
            last1_reg  <= item.last;
            start1_reg <= item.start;
        end
        if (en2)
        begin
            val2_reg   <= val2;
            nf2_reg    <= nfw2[IW-1:0];
            adif2_reg  <= mag2[IW-1:0];
            dest2_reg  <= dest1_reg;
            last2_reg  <= last1_reg;
            start2_reg <= start1_reg;
        end
        if (en3)
        begin
            sq3_reg    <= {{IW{1'b0}}, adif2_reg} * {{IW{1'b0}}, adif2_reg};
            val3_reg   <= val2_reg;
            nf3_reg    <= nf2_reg;
            dest3_reg  <= dest2_reg;
            last3_reg  <= last2_reg;
            start3_reg <= start2_reg;
        end
        if (en4 && v3_reg)
        begin
            val_o_reg  <= val3_reg;
            nf_o_reg   <= nf3_reg;
            dest_o_reg <= dest3_reg;
            last_o_reg <= last3_reg;
        end
    end

    assign out_valid   = ov_reg;
    assign intensity   = val_o_reg;
    assign noise_field = nf_o_reg;
    assign dest_index  = dest_o_reg;
    assign square_sum  = total_reg;
    assign frame_last  = last_o_reg;

endmodule

/* bench/intensity_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// intensity_checker
// Follows the register writes and the input items of the intensity mapper,
// predicts each result item and compares it with the block's output stream.
// ----------------------------------------------------------------------------
module intensity_checker (
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            s_axis_tvalid,
    input  logic                            s_axis_tready,
    input  logic [39:0]                     s_axis_tdata,   // [15:0] sample, [32:16] noise

    input  logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    input  logic [111:0]                    m_axis_tdata,   // [15:0] intensity,
                                                            // [31:16] noise_field,
                                                            // [55:32] dest_index,
                                                            // [111:56] square_sum
    input  logic                            m_axis_tlast,   // frame_last

    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [isfn_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [isfn_pkg::APB_DATA_W-1:0] pwdata,
    input  logic                            pready,

    output int                              fail_count,
    output int                              pending
);
    import isfn_pkg::*;

    typedef struct packed {
        logic [INTENS_W-1:0] intensity;
        logic [NFIELD_W-1:0] noise_field;
        logic [DEST_W-1:0]   dest_index;
        logic [SUM_W-1:0]    square_sum;
        logic                frame_last;
    } pixel_t;

    // register copy
    fmt_t                   cur_fmt   = FMT_S16;
    logic                   cur_inv   = 1'b0;
    logic [WIDTH_REG_W-1:0] cur_width = 13'd1;
    logic [COUNT_REG_W-1:0] cur_count = 25'd1;
    logic                   cur_nf_en = 1'b0;

    // frame state
    logic [DEST_W-1:0] dest_ptr = '0;
    int unsigned       col_cnt  = 0;
    logic [DONE_W-1:0] done_cnt = '0;
    logic [SUM_W-1:0]  sq_total = '0;

    pixel_t expected_pixels[$];
    int     mismatches = 0;
    int     results_seen = 0;

    // Map one sample, add noise, clamp, accumulate the squared difference, and advance the frame state.
    task automatic map_pixel(input logic [15:0] sample, input logic signed [16:0] noise,
                             output pixel_t res);
        int          s16, s8, nz, base, maxv, nlo, nhi, val, dif, nf;
        int unsigned w, c;
        logic [63:0] sq;
        logic        last;
        begin
            s16 = $signed(sample);
            s8  = $signed(sample[7:0]);
            nz  = noise;
            w = (cur_width == 0) ? 1 : cur_width;
            if (w > MAX_WIDTH_DEF) w = MAX_WIDTH_DEF;
            c = (cur_count == 0) ? 1 : cur_count;
            if (c > MAX_PIXELS_DEF) c = MAX_PIXELS_DEF;

            // new frame: reload the flipped row pointer, clear the sum
            if (done_cnt == 0) begin
                dest_ptr = 24'(c - w);
                col_cnt  = 0;
                sq_total = '0;
            end

            case (cur_fmt)
                FMT_S16:
                begin
                    base = cur_inv ? 32767 - s16 : s16 + 32768;
                    maxv = 65535;
                end
                FMT_U16:
                begin
                    base = cur_inv ? 65535 - int'(sample) : int'(sample);
                    maxv = 65535;
                end
                FMT_U8:
                begin
                    base = cur_inv ? 255 - int'(sample[7:0]) : int'(sample[7:0]);
                    maxv = 255;
                end
                default:
                begin
                    base = cur_inv ? 127 - s8 : 128 + s8;
                    maxv = 255;
                end
            endcase
            nhi = (maxv + 1) / 2 - 1;
            nlo = -((maxv + 1) / 2);

            val = base + nz;
            if (val < 0) val = 0;
            else if (val > maxv) val = maxv;
            dif = val - base;
            sq = (dif < 0) ? -dif : dif;
            sq = sq * sq;
            sq_total = sq_total + sq[SUM_W-1:0];

            nf = 0;
            if (cur_nf_en) begin
                nf = dif;
                if (nf < nlo) nf = nlo;
                else if (nf > nhi) nf = nhi;
            end

            last = (longint'(done_cnt) + 1) >= longint'(c);

            res.intensity   = val[INTENS_W-1:0];
            res.noise_field = nf[NFIELD_W-1:0];
            res.dest_index  = dest_ptr;
            res.square_sum  = sq_total;
            res.frame_last  = last;

            dest_ptr = dest_ptr + 24'd1;
            col_cnt  = col_cnt + 1;
            if (col_cnt >= w) begin
                col_cnt  = 0;
                dest_ptr = dest_ptr - 24'(2 * w);
            end
            done_cnt = last ? '0 : done_cnt + 24'd1;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin : track
        pixel_t exp_px;
        pixel_t act_px;
        if (!rst_n) begin
            cur_fmt   = FMT_S16;
            cur_inv   = 1'b0;
            cur_width = 13'd1;
            cur_count = 25'd1;
            cur_nf_en = 1'b0;
            dest_ptr  = '0;
            col_cnt   = 0;
            done_cnt  = '0;
            sq_total  = '0;
            expected_pixels.delete();
            pending    <= 0;
            fail_count <= mismatches;
        end
        else begin
            if (psel && penable && pwrite && pready) begin
                case (cfg_index_t'(paddr[APB_ADDR_W-1:2]))
                    CFG_SOURCE_FORMAT: cur_fmt   = fmt_t'(pwdata[FMT_W-1:0]);
                    CFG_INVERT_MODE:   cur_inv   = pwdata[0];
                    CFG_IMAGE_WIDTH:   cur_width = pwdata[WIDTH_REG_W-1:0];
                    CFG_PIXEL_COUNT:   cur_count = pwdata[COUNT_REG_W-1:0];
                    CFG_NOISE_ENABLE:  cur_nf_en = pwdata[0];
                    default:           ;
                endcase
            end

            if (s_axis_tvalid && s_axis_tready) begin
                map_pixel(s_axis_tdata[15:0], s_axis_tdata[32:16], exp_px);
                expected_pixels.push_back(exp_px);
            end

            if (m_axis_tvalid && m_axis_tready) begin
                act_px = {m_axis_tdata[15:0], m_axis_tdata[31:16], m_axis_tdata[55:32],
                          m_axis_tdata[111:56], m_axis_tlast};
                if (expected_pixels.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result %0d arrived with nothing outstanding: %h",
                                 results_seen, act_px);
                end
                else begin
                    exp_px = expected_pixels.pop_front();
                    if (act_px.intensity   !== exp_px.intensity   ||
                        act_px.noise_field !== exp_px.noise_field ||
                        act_px.dest_index  !== exp_px.dest_index  ||
                        act_px.square_sum  !== exp_px.square_sum  ||
                        act_px.frame_last  !== exp_px.frame_last) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("result %0d mismatch (exp/act): intensity %h/%h nf %h/%h",
                                     results_seen,
                                     exp_px.intensity, act_px.intensity,
                                     exp_px.noise_field, act_px.noise_field);
                            $display("    dest %h/%h sum %h/%h last %b/%b",
                                     exp_px.dest_index, act_px.dest_index,
                                     exp_px.square_sum, act_px.square_sum,
                                     exp_px.frame_last, act_px.frame_last);
                        end
                    end
                end
                results_seen++;
            end

            pending    <= expected_pixels.size();
            fail_count <= mismatches;
        end
    end

endmodule

/* bench/int_sample_to_intensity_flip_noise_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// int_sample_to_intensity_flip_noise_top_tb
// Drives pixel items and register settings into the intensity mapper under
// changing idle and stall patterns; a checker beside the block predicts and
// compares every result, and this top gives the verdict.
// ----------------------------------------------------------------------------
module int_sample_to_intensity_flip_noise_top_tb;
    import isfn_pkg::*;

    // Cycles without any accepted item before the run is declared hung.
    // The long receiver hold-off below is the slowest stretch by far.
    localparam int STALL_LIMIT     = 2000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int DRAIN_CYCLES    = 10;
    localparam int TARGET_ITEMS    = 500;

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;

    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [39:0]           s_axis_tdata  = '0;   // [15:0] sample, [32:16] noise

    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [111:0]          m_axis_tdata;         // [15:0] intensity, [31:16] noise_field,
                                                 // [55:32] dest_index, [111:56] square_sum
    logic                  m_axis_tlast;         // frame_last

    logic                  psel          = 1'b0;
    logic                  penable       = 1'b0;
    logic                  pwrite        = 1'b0;
    logic [APB_ADDR_W-1:0] paddr         = '0;
    logic [APB_DATA_W-1:0] pwdata        = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int fail_count;
    int pending;

    int idle_pct      = 0;    // sender gap chance per item, percent
    int stall_pct     = 0;    // receiver stall chance per cycle, percent
    int hold_requests = 0;    // bumped by the stimulus to ask for a long hold-off
    int hold_served   = 0;
    int hold_left     = 0;
    int quiet_cycles  = 0;
    int items_sent    = 0;

    always #1 clk = ~clk;

    int_sample_to_intensity_flip_noise_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    intensity_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    // Receiver: stall at random, or hold tready low for a long stretch when
    // the stimulus asks, so the queue fills and the input side backs up.
    always @(posedge clk) begin
        if (hold_requests != hold_served) begin
            hold_served   <= hold_requests;
            hold_left     <= HOLD_OFF_CYCLES;
            m_axis_tready <= 1'b0;
        end
        else if (hold_left != 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else begin
            m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // Watchdog: count cycles where neither channel moves an item.
    always @(posedge clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= STALL_LIMIT) begin
            $display("[int_sample_to_intensity_flip_noise_top] ERROR");
            $finish;
        end
        else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Write one register: setup phase, then access phase until pready,
    // then an idle phase before the bus can be used again.
    task automatic write_reg(input cfg_index_t idx, input logic [APB_DATA_W-1:0] value);
        begin
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= {idx, 2'b00};
            pwdata  <= value;
            @(posedge clk);
            penable <= 1'b1;
            @(posedge clk);
            while (!pready) @(posedge clk);
            psel    <= 1'b0;
            penable <= 1'b0;
            pwrite  <= 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic program_block(input fmt_t fmt, input logic inv, input int width,
                                 input int count, input logic nf_en);
        begin
            write_reg(CFG_SOURCE_FORMAT, 32'(fmt));
            write_reg(CFG_INVERT_MODE,   32'(inv));
            write_reg(CFG_IMAGE_WIDTH,   32'(width));
            write_reg(CFG_PIXEL_COUNT,   32'(count));
            write_reg(CFG_NOISE_ENABLE,  32'(nf_en));
        end
    endtask

    // Drop valid and wait until every predicted item has come out.
    task automatic wait_idle();
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
            while (pending != 0) @(posedge clk);
        end
    endtask

    // Pick the idle pattern: none, sender gaps, receiver stalls, or both.
    task automatic set_idling(input int mode);
        begin
            case (mode % 4)
                0:
                begin
                    idle_pct = 0;
                    stall_pct <= 0;
                end
                1:
                begin
                    idle_pct = 55;
                    stall_pct <= 0;
                end
                2:
                begin
                    idle_pct = 0;
                    stall_pct <= 55;
                end
                default:
                begin
                    idle_pct = 18;
                    stall_pct <= 18;
                end
            endcase
        end
    endtask

    // Offer one item, with a random gap in front, and hold it until accepted.
    task automatic send_pixel(input logic [15:0] sample, input logic signed [16:0] noise);
        begin
            while ($urandom_range(0, 99) < idle_pct) begin
                s_axis_tvalid <= 1'b0;
                @(posedge clk);
            end
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= {7'b0, noise, sample};
            @(posedge clk);
            while (!s_axis_tready) @(posedge clk);
            items_sent++;
        end
    endtask

    // Random items: noise mixes small values, mid values, the full range
    // and the two extremes so the clamps are hit from both sides.
    task automatic random_pixels(input int n);
        logic signed [16:0] nz;
        begin
            for (int i = 0; i < n; i++) begin
                case ($urandom_range(0, 3))
                    0:       nz = 17'($signed($urandom_range(0, 131070)) - 65535);
                    1:       nz = 17'($signed($urandom_range(0, 600)) - 300);
                    2:       nz = $urandom_range(0, 1) ? 17'sd65535 : -17'sd65535;
                    default: nz = 17'($signed($urandom_range(0, 4000)) - 2000);
                endcase
                send_pixel(16'($urandom_range(0, 65535)), nz);
            end
        end
    endtask

    task automatic run_phase(input fmt_t fmt, input logic inv, input int width,
                             input int count, input logic nf_en, input int n,
                             input int mode);
        begin
            wait_idle();
            program_block(fmt, inv, width, count, nf_en);
            set_idling(mode);
            random_pixels(n);
        end
    endtask

    initial begin : stimulus
        int phase;
        int width;
        int count;
        phase = 0;

        // hold reset, then release it once
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: every format in both mappings, one 3-pixel frame each.
        // Lowest sample with the largest positive noise, highest sample with
        // that noise negated, then a sample that sits at the signed
        // 8-bit minimum and near the signed 16-bit maximum with no noise.
        for (int f = 0; f < 4; f++) begin
            for (int inv = 0; inv < 2; inv++) begin
                wait_idle();
                program_block(fmt_t'(f), inv[0], 1, 3, 1'b1);
                set_idling(phase++);
                send_pixel(16'h0000, 17'sd65535);
                send_pixel(16'hFFFF, -17'sd65535);
                send_pixel(16'h7F80, 17'sd0);
            end
        end

        // Register extremes: width and count of zero act as one, oversized
        // values saturate, and a count that is not a multiple of the width.
        run_phase(FMT_S16, 1'b0, 4, 16, 1'b1, 60, phase++);
        run_phase(FMT_U8, 1'b1, 0, 0, 1'b0, 20, phase++);
        run_phase(FMT_S8, 1'b1, 8191, 33554431, 1'b1, 30, phase++);
        run_phase(FMT_U16, 1'b0, 4096, 16777216, 1'b1, 20, phase++);
        run_phase(FMT_S16, 1'b1, 3, 10, 1'b1, 40, phase++);
        run_phase(FMT_U16, 1'b1, 5, 25, 1'b0, 50, phase++);

        // Stop part way into a frame, then lower the count below the pixels
        // already done so the next pixel closes the frame.
        run_phase(FMT_S8, 1'b0, 4, 32, 1'b1, 13, phase++);
        run_phase(FMT_S8, 1'b0, 4, 8, 1'b1, 30, phase++);

        // Back-pressure: keep offering items while the receiver holds off.
        wait_idle();
        program_block(FMT_U8, 1'b0, 7, 49, 1'b1);
        set_idling(0);
        hold_requests <= hold_requests + 1;
        random_pixels(60);

        // Random settings, mostly small frames, some with a ragged last row.
        while (items_sent < TARGET_ITEMS) begin
            width = $urandom_range(1, 12);
            count = width * $urandom_range(1, 6);
            if ($urandom_range(0, 4) == 0) count = count + $urandom_range(1, width);
            run_phase(fmt_t'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), width, count,
                      1'($urandom_range(0, 1)), $urandom_range(20, 60), phase++);
        end

        // drain, let the pipeline settle, then report
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("[int_sample_to_intensity_flip_noise_top] OK");
        else
            $display("[int_sample_to_intensity_flip_noise_top] ERROR");
        $finish;
    end

endmodule
